// File: hdl/sdta_pkg.sv
// sdta_pkg: shared types, constants and tables for the signed decimal to ascii core
// no dependencies; imported by sdta_ctrl, sdta_dpath and signed_decimal_to_ascii_core

package sdta_pkg;

  // field widths fixed by the stream format
  localparam int IN_W        = 32;
  localparam int CHAR_W      = 6;
  localparam int COUNT_W     = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CHAR_W - COUNT_W;

  // default and largest supported value width
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int VALUE_WIDTH_MAX = 64;

  // digit position index covers up to 20 decimal digits, quotient bits per digit
  localparam int POS_W       = 5;
  localparam int BIT_W       = 2;
  localparam int DIGIT_W     = 4;
  localparam int RADIX       = 10;
  localparam int MAX_DIGITS  = 20;

  // ascii codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // powers of ten, index is the digit position
  localparam logic [VALUE_WIDTH_MAX-1:0] POW10 [MAX_DIGITS] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000,
    64'd10000000000000000,
    64'd100000000000000000,
    64'd1000000000000000000,
    64'd10000000000000000000
  };

  // command from controller to datapath
  typedef struct packed {
    logic             load;      // capture a new value and form its magnitude
    logic             trial;     // one compare-subtract step for the current digit
    logic             emit;      // write a character into the output register
    logic             sign_sel;  // emitted character is the minus sign
    logic             last;      // emitted character ends the number
    logic             clr_digit; // drop a leading zero digit
    logic [BIT_W-1:0] bit_sel;   // quotient bit under trial
    logic [POS_W-1:0] pos;       // current decimal position
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic neg;        // captured value is negative
    logic digit_zero; // finished digit is zero
    logic out_free;   // output register can take a character this cycle
  } status_t;

  // decimal digits needed for the largest w-bit unsigned value
  function automatic int dec_digits(input int w);
    logic [71:0] lim;
    logic [71:0] p;
    int          n;
    lim = 72'd1 << w;
    p   = 72'd1;
    n   = 0;
    for (int i = 0; i <= MAX_DIGITS; i++) begin
      if (p < lim) begin
        p = p * 72'(RADIX);
        n++;
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/signed_decimal_to_ascii_core.sv
// signed_decimal_to_ascii_core: top level, renders signed integers as decimal ascii items
// depends on sdta_pkg, sdta_ctrl and sdta_dpath
//
// channel   dir  handshake          payload
// in_*      in   tvalid / tready    tdata[31:0] value (signed)
// out_*     out  tvalid / tready    tdata[5:0] character, [37:6] running_count; tlast last_char
//
// an item runs a load step, a sign step, then per decimal position of the width (10 at 32
// bits) four trial steps and one emit or skip step; output stalls hold the sign and emit steps.
// its pace is set by the single compare-subtract unit, one quotient bit per cycle.
// a new item is taken the cycle after the previous one's last character is registered.
// reset clears the sequencer, output valid and the running count.
// a stalled output register holds the sequencer in place until it drains.

module signed_decimal_to_ascii_core #(
  parameter int VALUE_WIDTH = sdta_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sdta_pkg::IN_W-1:0]        in_tdata,   // [31:0] value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sdta_pkg::OUT_TDATA_W-1:0] out_tdata,  // [5:0] character, [37:6] running_count
  output logic                             out_tlast
);
  import sdta_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  sdta_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // digit datapath and output register
  sdta_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a character is only written when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("character written into a full output register");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after an accepted item");

  // only minus or digit codes leave the block
  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[CHAR_W-1:0] == ASCII_MINUS) ||
                    ((out_tdata[CHAR_W-1:0] >= ASCII_ZERO) &&
                     (out_tdata[CHAR_W-1:0] <= ASCII_ZERO + 6'd9))))
    else $error("character outside minus and digit codes");

  // the minus sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[CHAR_W-1:0] == ASCII_MINUS)) |-> !out_tlast)
    else $error("minus sign flagged as last character");

endmodule

// File: hdl/sdta_ctrl.sv
// sdta_ctrl: sequencer for sign, digit trials and character emission
// depends on sdta_pkg (cmd_t, status_t, dec_digits)

module sdta_ctrl #(
  parameter int VALUE_WIDTH = sdta_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sdta_pkg::status_t status,
  output sdta_pkg::cmd_t    cmd
);
  import sdta_pkg::*;

  localparam int NDIG = dec_digits(VALUE_WIDTH);
  localparam logic [POS_W-1:0] POS_INIT = POS_W'(NDIG - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SIGN  = 4'b0010,
    S_TRIAL = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             started_r, started_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    logic advance;
    advance     = 1'b0;
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    bit_nxt     = bit_r;
    started_nxt = started_r;
    cmd         = '0;
    cmd.pos     = pos_r;
    cmd.bit_sel = bit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load    = 1'b1;
          pos_nxt     = POS_INIT;
          bit_nxt     = '1;
          started_nxt = 1'b0;
          state_nxt   = S_SIGN;
        end
      end
      S_SIGN: begin
        if (!status.neg) begin
          state_nxt = S_TRIAL;
        end else if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.sign_sel = 1'b1;
          state_nxt    = S_TRIAL;
        end
      end
      S_TRIAL: begin
        cmd.trial = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      S_EMIT: begin
        // leading zeros are dropped, the units digit always prints
        if (status.digit_zero && !started_r && (pos_r != '0)) begin
          cmd.clr_digit = 1'b1;
          advance       = 1'b1;
        end else if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.last    = (pos_r == '0);
          started_nxt = 1'b1;
          advance     = 1'b1;
        end
        if (advance) begin
          if (pos_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r - 1'b1;
            bit_nxt   = '1;
            state_nxt = S_TRIAL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      bit_r     <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      bit_r     <= bit_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

// File: hdl/sdta_dpath.sv
// sdta_dpath: magnitude register, compare-subtract digit unit, output register and count
// depends on sdta_pkg (cmd_t, status_t, POW10, ascii codes)

module sdta_dpath #(
  parameter int VALUE_WIDTH = sdta_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [sdta_pkg::IN_W-1:0]          in_tdata,
  input  sdta_pkg::cmd_t                     cmd,
  output sdta_pkg::status_t                  status,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sdta_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);
  import sdta_pkg::*;

  localparam int TW = VALUE_WIDTH + 4;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] pow_w;
  logic [TW-1:0]          trial_val;
  logic                   trial_ge;

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [DIGIT_W-1:0]     digit_r, digit_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [COUNT_W-1:0]     count_inc;

  // input value at the configured width, upper bits zero when wider than the field
  assign raw = VALUE_WIDTH'(in_tdata);

  // scaled power of ten for the quotient bit under trial
  assign pow_w     = POW10[cmd.pos][VALUE_WIDTH-1:0];
  assign trial_val = TW'(pow_w) << cmd.bit_sel;
  assign trial_ge  = (TW'(mag_r) >= trial_val);

  // saturating character count
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  // datapath next values
  always_comb begin
    mag_nxt       = mag_r;
    digit_nxt     = digit_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;
    count_nxt     = count_r;
    if (cmd.load) begin
      neg_nxt   = raw[VALUE_WIDTH-1];
      mag_nxt   = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
      digit_nxt = '0;
    end
    if (cmd.trial && trial_ge) begin
      mag_nxt              = mag_r - trial_val[VALUE_WIDTH-1:0];
      digit_nxt[cmd.bit_sel] = 1'b1;
    end
    if (cmd.clr_digit) begin
      digit_nxt = '0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = cmd.sign_sel ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(digit_r));
      out_last_nxt  = cmd.last;
      out_count_nxt = count_inc;
      count_nxt     = count_inc;
      digit_nxt     = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    digit_r     <= digit_nxt;
    neg_r       <= neg_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  // status back to the controller
  assign status.neg        = neg_r;
  assign status.digit_zero = (digit_r == '0);
  assign status.out_free   = !out_valid_r || out_tready;

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_count_r, out_char_r};

endmodule
